/* hw/rtl/lavm_pkg.sv */
`default_nettype none

package lavm_pkg;

    // default coordinate width, signed q16.16
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;
    localparam int FRAC_ONE        = 65536;

    // unit vector components lie in [-1.0, 1.0], i.e. [-65536, 65536]
    localparam int UNIT_W  = 18;
    // exact cross product of two unit vectors
    localparam int CROSS_W = 35;

    // normalize: largest magnitude scaled into [2^29, 2^30)
    localparam int SCL_BITS   = 30;
    localparam int SQ_W       = 62;
    localparam int ROOT_STEPS = 31;
    localparam int Q_W        = 18;
    localparam int REM_W      = 48;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] LAST_ROW = 2'd3;

    // result handoff from the compute core to the row emitter
    typedef struct packed {
        logic valid;
        logic degen;
    } t_res_ctl;

endpackage

`default_nettype wire

/* hw/rtl/lavm_front.sv */
`default_nettype none

module lavm_front import lavm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [COORD_WIDTH-1:0]       i_eye_x,
    input  logic [COORD_WIDTH-1:0]       i_eye_y,
    input  logic [COORD_WIDTH-1:0]       i_eye_z,
    input  logic [COORD_WIDTH-1:0]       i_aim_x,
    input  logic [COORD_WIDTH-1:0]       i_aim_y,
    input  logic [COORD_WIDTH-1:0]       i_aim_z,
    input  logic [COORD_WIDTH-1:0]       i_up_x,
    input  logic [COORD_WIDTH-1:0]       i_up_y,
    input  logic [COORD_WIDTH-1:0]       i_up_z,
    output logic                         o_q_valid,
    input  logic                         i_q_pop,
    output logic [2:0][COORD_WIDTH:0]    o_d,
    output logic [2:0][COORD_WIDTH-1:0]  o_eye,
    output logic [2:0][COORD_WIDTH-1:0]  o_up
);

    localparam int W     = COORD_WIDTH;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [2:0][W:0]   r_mem_d   [QUEUE_DEPTH];
    logic [2:0][W-1:0] r_mem_eye [QUEUE_DEPTH];
    logic [2:0][W-1:0] r_mem_up  [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;

    logic [2:0][W-1:0] eye_in;
    logic [2:0][W-1:0] aim_in;
    logic [2:0][W-1:0] up_in;
    logic [2:0][W:0]   d_in;
    logic              push;
    logic              pop;

    always_comb begin
        eye_in = {i_eye_z, i_eye_y, i_eye_x};
        aim_in = {i_aim_z, i_aim_y, i_aim_x};
        up_in  = {i_up_z, i_up_y, i_up_x};
        for (int i = 0; i < 3; i++) begin
            // view direction, one bit wider so it never wraps
            d_in[i] = $signed({aim_in[i][W-1], aim_in[i]})
                    - $signed({eye_in[i][W-1], eye_in[i]});
        end
    end

    assign o_in_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != '0);
    assign pop        = i_q_pop && o_q_valid;

    assign o_d   = r_mem_d[r_rp];
    assign o_eye = r_mem_eye[r_rp];
    assign o_up  = r_mem_up[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem_d[r_wp]   <= d_in;
            r_mem_eye[r_wp] <= eye_in;
            r_mem_up[r_wp]  <= up_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lavm_core.sv */
`default_nettype none

module lavm_core import lavm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  logic [2:0][COORD_WIDTH:0]     i_d,
    input  logic [2:0][COORD_WIDTH-1:0]   i_eye,
    input  logic [2:0][COORD_WIDTH-1:0]   i_up,
    output t_res_ctl                      o_res,
    input  logic                          i_res_ready,
    output logic [2:0][UNIT_W-1:0]        o_ax,
    output logic [2:0][UNIT_W-1:0]        o_ay,
    output logic [2:0][UNIT_W-1:0]        o_az,
    output logic [2:0][COORD_WIDTH+2:0]   o_t
);

    localparam int W  = COORD_WIDTH;
    localparam int VW = (W + 1 > CROSS_W) ? W + 1 : CROSS_W;
    localparam int SW = W + 3;
    localparam int PW = W + UNIT_W - 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_SHIFT = 4'd2;
    localparam logic [3:0] ST_SQ    = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_DINIT = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_STORE = 4'd7;
    localparam logic [3:0] ST_CROSS = 4'd8;
    localparam logic [3:0] ST_DOT   = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]               r_state;
    logic [1:0]               r_job;
    logic [4:0]               r_cnt;
    logic                     r_degen;
    logic signed [W:0]        r_d   [3];
    logic signed [W-1:0]      r_eye [3];
    logic signed [W-1:0]      r_up  [3];
    logic [VW-1:0]            r_m   [3];
    logic                     r_sgn [3];
    logic [VW-1:0]            r_top;
    logic [SQ_W-1:0]          r_sq;
    logic [SQ_W-1:0]          r_root;
    logic [SQ_W-1:0]          r_bit;
    logic [REM_W-1:0]         r_rem [3];
    logic [REM_W-1:0]         r_div;
    logic [Q_W-1:0]           r_q   [3];
    logic signed [UNIT_W-1:0] r_un  [3];
    logic signed [UNIT_W-1:0] r_az  [3];
    logic signed [UNIT_W-1:0] r_ax  [3];
    logic signed [UNIT_W-1:0] r_ay  [3];
    logic signed [CROSS_W-1:0] r_c  [3];
    logic signed [SW-1:0]     r_t   [3];

    logic signed [VW-1:0]     v_sel [3];
    logic [VW-1:0]            mg    [3];
    logic [VW-1:0]            top_ld;
    logic                     all_zero;
    logic [SCL_BITS-1:0]      sq_m;
    logic [SQ_W-1:0]          sq_term;
    logic [SQ_W-1:0]          trial;
    logic                     root_ge;
    logic [ROOT_STEPS-1:0]    len;
    logic                     div_ge [3];
    logic signed [UNIT_W-1:0] unit_v [3];
    logic [1:0]               ia;
    logic [1:0]               ib;
    logic signed [UNIT_W-1:0] op_a;
    logic signed [UNIT_W-1:0] op_b;
    logic signed [2*UNIT_W-1:0] prod;
    logic [1:0]               ci;
    logic signed [UNIT_W-1:0] d_axis;
    logic signed [W-1:0]      d_eye;
    logic [UNIT_W-2:0]        amag;
    logic [W-1:0]             emag;
    logic [PW-1:0]            prodd;
    logic [PW-1:0]            rnd;
    logic [W:0]               tr;
    logic signed [SW-1:0]     term;

    // vector to normalize and its magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (r_job)
                2'd0:    v_sel[i] = VW'(r_d[i]);
                2'd1:    v_sel[i] = VW'(r_up[i]);
                default: v_sel[i] = VW'(r_c[i]);
            endcase
            mg[i] = v_sel[i][VW-1] ? VW'(-v_sel[i]) : VW'(v_sel[i]);
        end
        top_ld = (mg[0] > mg[1]) ? mg[0] : mg[1];
        if (mg[2] > top_ld) begin
            top_ld = mg[2];
        end
        all_zero = (mg[0] == '0) && (mg[1] == '0) && (mg[2] == '0);
    end

    // sum of squares, square root and the three divide lanes
    always_comb begin
        sq_m    = r_m[r_cnt[1:0]][SCL_BITS-1:0];
        sq_term = SQ_W'(sq_m) * SQ_W'(sq_m);
        trial   = r_root + r_bit;
        root_ge = (r_sq >= trial);
        len     = r_root[ROOT_STEPS-1:0];
        for (int i = 0; i < 3; i++) begin
            div_ge[i] = (r_rem[i] >= r_div);
            unit_v[i] = r_sgn[i] ? -$signed(r_q[i]) : $signed(r_q[i]);
        end
    end

    // cross product, one partial product a cycle
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    begin ia = 2'd1; ib = 2'd2; end
            3'd1:    begin ia = 2'd2; ib = 2'd1; end
            3'd2:    begin ia = 2'd2; ib = 2'd0; end
            3'd3:    begin ia = 2'd0; ib = 2'd2; end
            3'd4:    begin ia = 2'd0; ib = 2'd1; end
            default: begin ia = 2'd1; ib = 2'd0; end
        endcase
        op_a = (r_job == 2'd1) ? r_un[ia] : r_az[ia];
        op_b = (r_job == 2'd1) ? r_az[ib] : r_ax[ib];
        prod = op_a * op_b;
    end

    // translation term: axis times negated eye, rounded per product
    always_comb begin
        ci = r_cnt[1:0];
        case (r_job)
            2'd0:    d_axis = r_ax[ci];
            2'd1:    d_axis = r_ay[ci];
            default: d_axis = r_az[ci];
        endcase
        d_eye = r_eye[ci];
        amag  = d_axis[UNIT_W-1] ? (UNIT_W-1)'(-d_axis) : (UNIT_W-1)'(d_axis);
        emag  = d_eye[W-1] ? W'(-d_eye) : W'(d_eye);
        prodd = PW'(amag) * PW'(emag);
        rnd   = prodd + PW'(1 << (FRAC_BITS - 1));
        tr    = rnd[PW-1:FRAC_BITS];
        term  = (d_axis[UNIT_W-1] != d_eye[W-1]) ? $signed({2'b00, tr})
                                                  : -$signed({2'b00, tr});
    end

    assign o_q_pop   = (r_state == ST_IDLE) && i_q_valid;
    assign o_res.valid = (r_state == ST_DONE);
    assign o_res.degen = r_degen;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_ax[i] = r_ax[i];
            o_ay[i] = r_ay[i];
            o_az[i] = r_az[i];
            o_t[i]  = r_t[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_d[i]   <= $signed(i_d[i]);
                            r_eye[i] <= $signed(i_eye[i]);
                            r_up[i]  <= $signed(i_up[i]);
                        end
                        r_degen <= 1'b0;
                        r_job   <= 2'd0;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i]   <= mg[i];
                        r_sgn[i] <= v_sel[i][VW-1];
                        r_q[i]   <= '0;
                    end
                    r_top <= top_ld;
                    if (all_zero) begin
                        r_degen <= 1'b1;
                        r_state <= ST_STORE;
                    end else begin
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    if (|r_top[VW-1:SCL_BITS]) begin
                        r_top <= r_top >> 1;
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] >> 1;
                        end
                    end else if (!r_top[SCL_BITS-1]) begin
                        r_top <= r_top << 1;
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] << 1;
                        end
                    end else begin
                        r_cnt   <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_sq <= ((r_cnt == '0) ? '0 : r_sq) + sq_term;
                    if (r_cnt == 5'd2) begin
                        r_cnt   <= '0;
                        r_root  <= '0;
                        r_bit   <= SQ_W'(1) << (SQ_W - 2);
                        r_state <= ST_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SQRT: begin
                    if (root_ge) begin
                        r_sq   <= r_sq - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 5'(ROOT_STEPS - 1)) begin
                        r_state <= ST_DINIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DINIT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= REM_W'({r_m[i][SCL_BITS-1:0], {FRAC_BITS{1'b0}}})
                                  + REM_W'(len >> 1);
                    end
                    r_div   <= REM_W'({len, {(Q_W-1){1'b0}}});
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        if (div_ge[i]) begin
                            r_rem[i] <= r_rem[i] - r_div;
                            r_q[i]   <= {r_q[i][Q_W-2:0], 1'b1};
                        end else begin
                            r_q[i]   <= {r_q[i][Q_W-2:0], 1'b0};
                        end
                    end
                    r_div <= r_div >> 1;
                    if (r_cnt == 5'(Q_W - 1)) begin
                        r_state <= ST_STORE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_STORE: begin
                    for (int i = 0; i < 3; i++) begin
                        case (r_job)
                            2'd0:    r_az[i] <= unit_v[i];
                            2'd1:    r_un[i] <= unit_v[i];
                            2'd2:    r_ax[i] <= unit_v[i];
                            default: r_ay[i] <= unit_v[i];
                        endcase
                    end
                    r_cnt <= '0;
                    case (r_job)
                        2'd0: begin
                            r_job   <= 2'd1;
                            r_state <= ST_LOAD;
                        end
                        2'd1, 2'd2: begin
                            r_state <= ST_CROSS;
                        end
                        default: begin
                            r_job   <= 2'd0;
                            r_state <= ST_DOT;
                        end
                    endcase
                end
                ST_CROSS: begin
                    if (!r_cnt[0]) begin
                        r_c[r_cnt[2:1]] <= CROSS_W'(prod);
                    end else begin
                        r_c[r_cnt[2:1]] <= r_c[r_cnt[2:1]] - CROSS_W'(prod);
                    end
                    if (r_cnt == 5'd5) begin
                        r_job   <= r_job + 1'b1;
                        r_state <= ST_LOAD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DOT: begin
                    r_t[r_job] <= ((r_cnt == '0) ? '0 : r_t[r_job]) + term;
                    if (r_cnt == 5'd2) begin
                        r_cnt <= '0;
                        if (r_job == 2'd2) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_job <= r_job + 1'b1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lavm_emit.sv */
`default_nettype none

module lavm_emit import lavm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_res_ctl                      i_res,
    output logic                          o_res_ready,
    input  logic [2:0][UNIT_W-1:0]        i_ax,
    input  logic [2:0][UNIT_W-1:0]        i_ay,
    input  logic [2:0][UNIT_W-1:0]        i_az,
    input  logic [2:0][COORD_WIDTH+2:0]   i_t,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_row_index,
    output logic [COORD_WIDTH-1:0]        o_elem0,
    output logic [COORD_WIDTH-1:0]        o_elem1,
    output logic [COORD_WIDTH-1:0]        o_elem2,
    output logic [COORD_WIDTH-1:0]        o_elem3,
    output logic                          o_degenerate,
    output logic                          o_last_row
);

    localparam int W  = COORD_WIDTH;
    localparam int SW = W + 3;

    logic [W-1:0] r_e [4][4];
    logic [1:0]   r_row;
    logic         r_busy;
    logic         r_degen;
    logic         load;
    logic         last_take;

    // clamp to the signed coordinate range
    function automatic logic [W-1:0] sat(input logic [SW-1:0] v);
        logic fits;
        fits = (v[SW-1:W-1] == '0) || (v[SW-1:W-1] == '1);
        if (fits) begin
            return v[W-1:0];
        end
        return v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    assign last_take    = r_busy && i_out_ready && (r_row == LAST_ROW);
    assign o_res_ready  = !r_busy || last_take;
    assign load         = i_res.valid && o_res_ready;

    assign o_out_valid  = r_busy;
    assign o_row_index  = r_row;
    assign o_elem0      = r_e[r_row][0];
    assign o_elem1      = r_e[r_row][1];
    assign o_elem2      = r_e[r_row][2];
    assign o_elem3      = r_e[r_row][3];
    assign o_degenerate = r_degen;
    assign o_last_row   = (r_row == LAST_ROW);

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int r = 0; r < 3; r++) begin
                r_e[r][0] <= sat(SW'($signed(i_ax[r])));
                r_e[r][1] <= sat(SW'($signed(i_ay[r])));
                r_e[r][2] <= sat(SW'($signed(i_az[r])));
                r_e[r][3] <= '0;
            end
            r_e[3][0] <= sat(i_t[0]);
            r_e[3][1] <= sat(i_t[1]);
            r_e[3][2] <= sat(i_t[2]);
            r_e[3][3] <= sat(SW'(FRAC_ONE));
            r_degen   <= i_res.degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_row  <= '0;
            end else if (r_busy && i_out_ready) begin
                if (r_row == LAST_ROW) begin
                    r_busy <= 1'b0;
                    r_row  <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/look_at_view_matrix_unit.sv */
`default_nettype none

// left-handed look-at view matrix. each input item carries eye, target and
// up vectors in signed q16.16; the block returns the 4x4 view matrix as four
// items, rows 0 to 3 in order, row_index counting the row and last_row high on
// row 3. rows 0-2 hold the right, up and forward axis components with 0 in
// column 3; row 3 holds the translation terms and 1.0. every element is
// clamped to the signed coordinate range. degenerate is set on all four rows
// when any normalize met a zero-length vector, the affected axis then reads
// as zeros. timing: a new item is taken into a two-entry queue while an
// earlier one is being worked on; the back end's time per matrix is set by
// the shared iterative normalize unit (leading-bit scaling one bit a cycle,
// 31 square-root steps and 18 divide steps per axis, four axes per matrix),
// plus the cross products and the dot unit. a zero-length vector skips the
// scaling, square-root and divide steps of its normalize. sustained input
// rate is therefore one item per matrix time. the four rows then leave at
// one per cycle while the receiver is ready, and while the next matrix is
// computed.
module look_at_view_matrix_unit import lavm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input item channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [COORD_WIDTH-1:0] i_eye_x,
    input  logic [COORD_WIDTH-1:0] i_eye_y,
    input  logic [COORD_WIDTH-1:0] i_eye_z,
    input  logic [COORD_WIDTH-1:0] i_aim_x,
    input  logic [COORD_WIDTH-1:0] i_aim_y,
    input  logic [COORD_WIDTH-1:0] i_aim_z,
    input  logic [COORD_WIDTH-1:0] i_up_x,
    input  logic [COORD_WIDTH-1:0] i_up_y,
    input  logic [COORD_WIDTH-1:0] i_up_z,
    // matrix row channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_row_index,
    output logic [COORD_WIDTH-1:0] o_elem0,
    output logic [COORD_WIDTH-1:0] o_elem1,
    output logic [COORD_WIDTH-1:0] o_elem2,
    output logic [COORD_WIDTH-1:0] o_elem3,
    output logic                   o_degenerate,
    output logic                   o_last_row
);

    // queue to core
    logic                         q_valid;
    logic                         q_pop;
    logic [2:0][COORD_WIDTH:0]    q_d;
    logic [2:0][COORD_WIDTH-1:0]  q_eye;
    logic [2:0][COORD_WIDTH-1:0]  q_up;

    // core to row emitter
    t_res_ctl                     res;
    logic                         res_ready;
    logic [2:0][UNIT_W-1:0]       res_ax;
    logic [2:0][UNIT_W-1:0]       res_ay;
    logic [2:0][UNIT_W-1:0]       res_az;
    logic [2:0][COORD_WIDTH+2:0]  res_t;

    // front: takes items, forms the view direction, buffers two items
    lavm_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_eye_x    (i_eye_x),
        .i_eye_y    (i_eye_y),
        .i_eye_z    (i_eye_z),
        .i_aim_x    (i_aim_x),
        .i_aim_y    (i_aim_y),
        .i_aim_z    (i_aim_z),
        .i_up_x     (i_up_x),
        .i_up_y     (i_up_y),
        .i_up_z     (i_up_z),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_d        (q_d),
        .o_eye      (q_eye),
        .o_up       (q_up)
    );

    // back: normalizes, cross products and translation dot products
    lavm_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_d         (q_d),
        .i_eye       (q_eye),
        .i_up        (q_up),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_ax        (res_ax),
        .o_ay        (res_ay),
        .o_az        (res_az),
        .o_t         (res_t)
    );

    // output stage: clamps and sends the four rows
    lavm_emit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res        (res),
        .o_res_ready  (res_ready),
        .i_ax         (res_ax),
        .i_ay         (res_ay),
        .i_az         (res_az),
        .i_t          (res_t),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_row_index  (o_row_index),
        .o_elem0      (o_elem0),
        .o_elem1      (o_elem1),
        .o_elem2      (o_elem2),
        .o_elem3      (o_elem3),
        .o_degenerate (o_degenerate),
        .o_last_row   (o_last_row)
    );

`ifndef NO_ASSERTIONS
    // last_row marks row 3 and nothing else
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_row == (o_row_index == LAST_ROW)))
        else $error("last_row does not match row_index");

    // rows of one matrix follow each other in order
    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_row) |=>
            (o_out_valid && (o_row_index == 2'($past(o_row_index) + 2'd1))))
        else $error("matrix row skipped");

    // rotation rows carry zero in column 3
    a_col3_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_row) |-> (o_elem3 == '0))
        else $error("column 3 not zero on rotation row");

    // the flag is the same on every row of a matrix
    a_degen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_row) |=>
            (o_degenerate == $past(o_degenerate)))
        else $error("degenerate flag changed inside a matrix");
`endif

endmodule

`default_nettype wire

/* test/tb_look_at_view_matrix_unit.sv */
`default_nettype none

module tb_look_at_view_matrix_unit;
    import lavm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 32;
    localparam int HOLD_LEN  = 800;   // long receiver hold-off, in cycles
    localparam int IDLE_MAX  = 6000;  // watchdog: cycles with no item moving
    localparam int TAIL_CYC  = 400;   // latency allowance after the last row

    // one matrix row as the block should emit it
    typedef struct {
        logic [1:0]    row;
        logic [CW-1:0] e0, e1, e2, e3;
        logic          degen;
        logic          last;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic [CW-1:0] i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic [CW-1:0] i_aim_x = '0, i_aim_y = '0, i_aim_z = '0;
    logic [CW-1:0] i_up_x = '0, i_up_y = '0, i_up_z = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic [1:0]    o_row_index;
    logic [CW-1:0] o_elem0, o_elem1, o_elem2, o_elem3;
    logic          o_degenerate;
    logic          o_last_row;

    t_row expected_rows[$];
    int   n_errors   = 0;
    int   n_items    = 0;
    int   n_rows     = 0;
    int   n_degen    = 0;
    bit   hold_req   = 1'b0;
    int   idle_cnt   = 0;

    look_at_view_matrix_unit #(.COORD_WIDTH(CW)) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_eye_x      (i_eye_x),
        .i_eye_y      (i_eye_y),
        .i_eye_z      (i_eye_z),
        .i_aim_x      (i_aim_x),
        .i_aim_y      (i_aim_y),
        .i_aim_z      (i_aim_z),
        .i_up_x       (i_up_x),
        .i_up_y       (i_up_y),
        .i_up_z       (i_up_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_row_index  (o_row_index),
        .o_elem0      (o_elem0),
        .o_elem1      (o_elem1),
        .o_elem2      (o_elem2),
        .o_elem3      (o_elem3),
        .o_degenerate (o_degenerate),
        .o_last_row   (o_last_row)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // fixed-point predictor of the view matrix
    // ---------------------------------------------------------------

    function automatic longint unsigned abs64(input longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s_in);
        longint unsigned s, r, b;
        s = s_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // unit vector in q16.16; returns 1 when the vector is all zero
    function automatic bit unit_vec(input longint v0, v1, v2,
                                    output longint u0, u1, u2);
        longint unsigned m[3];
        longint unsigned top, s, len, q;
        longint v[3];
        longint u[3];
        v[0] = v0; v[1] = v1; v[2] = v2;
        for (int i = 0; i < 3; i++) m[i] = abs64(v[i]);
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        if (top == 0) begin
            u0 = 0; u1 = 0; u2 = 0;
            return 1'b1;
        end
        // scale the largest magnitude into [2^29, 2^30)
        while (top >= (64'd1 << 30)) begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (top < (64'd1 << 29)) begin
            top = top << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 16) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        u0 = u[0]; u1 = u[1]; u2 = u[2];
        return 1'b0;
    endfunction

    // translation term: dot(axis, -eye), each product rounded on its own
    function automatic longint neg_eye_dot(input longint a0, a1, a2,
                                           input longint e0, e1, e2);
        longint a[3], e[3];
        longint sum, t;
        longint unsigned p;
        a[0] = a0; a[1] = a1; a[2] = a2;
        e[0] = e0; e[1] = e1; e[2] = e2;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            p = abs64(a[i]) * abs64(e[i]);
            t = longint'((p + 64'd32768) >> 16);
            sum += ((a[i] < 0) != (e[i] < 0)) ? t : -t;
        end
        return sum;
    endfunction

    function automatic logic [CW-1:0] clamp_coord(input longint v);
        longint hi, lo;
        hi = (longint'(1) << (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    // work out the four rows for one item and queue them
    task automatic predict_view_matrix(input logic [CW-1:0] ex, ey, ez,
                                       input logic [CW-1:0] ax_, ay_, az_,
                                       input logic [CW-1:0] ux, uy, uz);
        longint eye0, eye1, eye2, fw0, fw1, fw2, un0, un1, un2;
        longint rt0, rt1, rt2, vu0, vu1, vu2, c0, c1, c2;
        longint t0, t1, t2;
        bit     dg;
        t_row   r;
        eye0 = longint'($signed(ex));
        eye1 = longint'($signed(ey));
        eye2 = longint'($signed(ez));
        dg = unit_vec(longint'($signed(ax_)) - eye0, longint'($signed(ay_)) - eye1,
                      longint'($signed(az_)) - eye2, fw0, fw1, fw2);
        dg |= unit_vec(longint'($signed(ux)), longint'($signed(uy)),
                       longint'($signed(uz)), un0, un1, un2);
        // right = up x forward, exact products
        c0 = un1 * fw2 - un2 * fw1;
        c1 = un2 * fw0 - un0 * fw2;
        c2 = un0 * fw1 - un1 * fw0;
        dg |= unit_vec(c0, c1, c2, rt0, rt1, rt2);
        // view up = forward x right
        c0 = fw1 * rt2 - fw2 * rt1;
        c1 = fw2 * rt0 - fw0 * rt2;
        c2 = fw0 * rt1 - fw1 * rt0;
        dg |= unit_vec(c0, c1, c2, vu0, vu1, vu2);
        t0 = neg_eye_dot(rt0, rt1, rt2, eye0, eye1, eye2);
        t1 = neg_eye_dot(vu0, vu1, vu2, eye0, eye1, eye2);
        t2 = neg_eye_dot(fw0, fw1, fw2, eye0, eye1, eye2);
        if (dg) n_degen++;
        r.degen = dg;
        r.e3 = '0;
        r.last = 1'b0;
        r.row = 2'd0;
        r.e0 = clamp_coord(rt0); r.e1 = clamp_coord(vu0); r.e2 = clamp_coord(fw0);
        expected_rows = {expected_rows, r};
        r.row = 2'd1;
        r.e0 = clamp_coord(rt1); r.e1 = clamp_coord(vu1); r.e2 = clamp_coord(fw1);
        expected_rows = {expected_rows, r};
        r.row = 2'd2;
        r.e0 = clamp_coord(rt2); r.e1 = clamp_coord(vu2); r.e2 = clamp_coord(fw2);
        expected_rows = {expected_rows, r};
        r.row = LAST_ROW;
        r.last = 1'b1;
        r.e0 = clamp_coord(t0); r.e1 = clamp_coord(t1); r.e2 = clamp_coord(t2);
        r.e3 = clamp_coord(FRAC_ONE);
        expected_rows = {expected_rows, r};
    endtask

    // ---------------------------------------------------------------
    // sender: called at a falling edge, returns at a falling edge with
    // valid still high so a back-to-back item never drops it
    // ---------------------------------------------------------------
    task automatic send_item(input logic [CW-1:0] ex, ey, ez,
                             input logic [CW-1:0] ax_, ay_, az_,
                             input logic [CW-1:0] ux, uy, uz);
        i_eye_x = ex;  i_eye_y = ey;  i_eye_z = ez;
        i_aim_x = ax_; i_aim_y = ay_; i_aim_z = az_;
        i_up_x = ux;   i_up_y = uy;   i_up_z = uz;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_view_matrix(ex, ey, ez, ax_, ay_, az_, ux, uy, uz);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained;
        while (expected_rows.size() != 0) @(negedge i_clk);
    endtask

    // random coordinate, magnitude class picked at random
    function automatic logic [CW-1:0] rand_coord;
        logic [CW-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: return v;
            1: return $signed(v) >>> $urandom_range(8, 30);
            default: return $signed(v) >>> $urandom_range(0, 14);
        endcase
    endfunction

    // mostly well-formed cameras, plus degenerate and raw noise items
    task automatic send_random_item;
        logic [CW-1:0] e[3], a[3], u[3];
        int kind;
        kind = $urandom_range(0, 11);
        for (int i = 0; i < 3; i++) begin
            e[i] = rand_coord();
            a[i] = ($urandom_range(0, 1) != 0) ? e[i] + ($signed(rand_coord()) >>> 4)
                                                : rand_coord();
            u[i] = rand_coord();
        end
        case (kind)
            8: a = e;                                      // target on the eye
            9: u = '{default: '0};                         // no up direction
            10: for (int i = 0; i < 3; i++) u[i] = a[i] - e[i]; // up along view
            11: for (int i = 0; i < 3; i++) begin
                e[i] = $urandom; a[i] = $urandom; u[i] = $urandom;
            end
            default: ;
        endcase
        send_item(e[0], e[1], e[2], a[0], a[1], a[2], u[0], u[1], u[2]);
    endtask

    // ---------------------------------------------------------------
    // receiver: own stall pattern, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_LEN - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(20, 300);
                end
                left--;
                case (mode)
                    0: i_out_ready = 1'b1;                          // no stalls
                    1: i_out_ready = ($urandom_range(0, 9) > 2);    // light stalls
                    default: i_out_ready = ($urandom_range(0, 9) > 6);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_row x;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_rows++;
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row %0d, nothing pending", $time, o_row_index);
                n_errors++;
            end else begin
                x = expected_rows.pop_front();
                if (o_row_index !== x.row || o_elem0 !== x.e0 || o_elem1 !== x.e1 ||
                    o_elem2 !== x.e2 || o_elem3 !== x.e3 ||
                    o_degenerate !== x.degen || o_last_row !== x.last) begin
                    $display("%0t: row mismatch exp row=%0d %h %h %h %h dg=%b lr=%b",
                             $time, x.row, x.e0, x.e1, x.e2, x.e3, x.degen, x.last);
                    $display("%0t:              got row=%0d %h %h %h %h dg=%b lr=%b",
                             $time, o_row_index, o_elem0, o_elem1, o_elem2, o_elem3,
                             o_degenerate, o_last_row);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cnt <= 0;
        end else if (i_rst_n) begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt > IDLE_MAX) begin
                $display("timeout at %0t, %0d rows still pending", $time,
                         expected_rows.size());
                $display("tb_look_at_view_matrix_unit: done, errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    localparam logic [CW-1:0] ONE  = 32'h0001_0000;
    localparam logic [CW-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [CW-1:0] MINV = 32'h8000_0000;

    task automatic test_directed;
        // plain cameras, the first at the origin looking down +z
        send_item(0, 0, 0, 0, 0, ONE, 0, ONE, 0);
        send_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0);
        send_item(ONE, 2*ONE, -3*ONE, 0, 0, 0, 0, ONE, 0);
        // far corners of the coordinate range, translation saturates
        send_item(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MINV);
        send_item(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, 0);
        send_item(MAXV, MINV, MAXV, MINV, MAXV, MINV, 1, 1, 1);
        idle_gap(3);
        // target on the eye: degenerate forward and everything after it
        send_item(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0);
        // zero up vector
        send_item(0, 0, 0, 0, 0, ONE, 0, 0, 0);
        // up along the view direction: cross product vanishes
        send_item(0, 0, 0, 0, ONE, 0, 0, 5*ONE, 0);
        send_item(0, 0, 0, 0, 0, -ONE, 0, 0, MAXV);
        // smallest nonzero vectors, scaled up inside the normalize
        send_item(0, 0, 0, 1, 0, 0, 0, 0, 1);
        send_item(0, 0, 0, -1, -1, -1, 1, -1, 0);
        idle_gap(1);
        // half-way rounding of translation products
        send_item(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 0, 0, 0, ONE, 0);
        send_item(32'hffff_8000, 32'h0000_0001, 32'hffff_ffff, ONE, ONE, ONE,
                  0, 0, ONE);
        // all-ones and alternating bit patterns
        send_item('1, '1, '1, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                  32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        send_item(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, '1, '1, 0,
                  32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
        idle_gap(2);
    endtask

    // bursts of random length with random gaps
    task automatic test_random(input int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 6);
            while (burst > 0 && n > 0) begin
                send_random_item();
                burst--;
                n--;
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400));
        end
        i_in_valid = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure;
        hold_req = 1'b1;
        repeat (8) send_random_item();
        i_in_valid = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        i_in_valid = 1'b0;
        wait_drained();          // sender pauses until every row is back
        test_random(90);
        test_backpressure();
        test_random(100);
        wait_drained();
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("covered %0d matrices (%0d degenerate), %0d rows checked,",
                 n_items, n_degen, n_rows);
        $display("with bursty input, random output stalls and one long hold-off");
        if (n_errors == 0 && expected_rows.size() == 0) begin
            $display("tb_look_at_view_matrix_unit: done, clean");
        end else begin
            $display("tb_look_at_view_matrix_unit: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
